@@ sv/gbn_pkg.sv @@
// ---------------------------------------------------------------------------
// gbn_pkg
// Shared codes, widths and control/status types for the Go-Back-N sender.
// ---------------------------------------------------------------------------
package gbn_pkg;

    localparam int OP_W      = 2;
    localparam int ACK_W     = 3;
    localparam int KIND_W    = 2;
    localparam int SEQ_OUT_W = 3;
    localparam int OUTST_W   = 3;
    localparam int WIN_W     = 3;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // input operations
    localparam logic [OP_W-1:0] OP_SEND = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETX   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'd1;

    localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST = 3'd7;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST     = 16'd2000;
    localparam logic [TIMER_W-1:0] TIMER_MAX       = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the input item, load its first result
        logic advance;  // current beat taken, load next retransmission
    } gbn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;     // the held result is the final one of its item
    } gbn_sts_t;

endpackage

@@ sv/go_back_n_sender_window.sv @@
// ---------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N ARQ sender window: grants sends, takes cumulative acks and
// retransmits the whole outstanding window on timer expiry.
// ---------------------------------------------------------------------------
//
//  channel  | signals                                   | beat on
//  ---------+-------------------------------------------+---------------------
//  in       | in_valid, in_ready, op, ack_seq           | in_valid & in_ready
//  out      | out_valid, out_ready, kind, seq_num,      | out_valid & out_ready
//           | outstanding, last                         |
//  cfg      | cfg_we, cfg_index, cfg_data               | cfg_we
//
//  An item is taken on an in beat and its result sits in the output register
//  from the next cycle; an item gives one beat, a timeout one beat for each
//  of its N retransmissions (N at most 7), one beat per cycle from the result
//  register while out_ready is high. One item is in flight at a time;
//  in_ready returns the cycle after the final beat is taken. After reset the
//  window is empty, the timer stopped, window_size 7 and timeout 2000 ticks.
//  A stall on out holds the current beat and the whole block.
//
module go_back_n_sender_window #(
    parameter int SEQ_MODULUS = 8   // sequence number space, 2 to 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DAT_W-1:0]  cfg_data,
    // input events
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [gbn_pkg::OP_W-1:0]       op,
    input  logic [gbn_pkg::ACK_W-1:0]      ack_seq,
    // results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gbn_pkg::KIND_W-1:0]     kind,
    output logic [gbn_pkg::SEQ_OUT_W-1:0]  seq_num,
    output logic [gbn_pkg::OUTST_W-1:0]    outstanding,
    output logic                           last
);
    import gbn_pkg::*;

    // command/status link between controller and datapath
    gbn_cmd_t cmd;
    gbn_sts_t sts;

    // Controller: owns the handshakes. It accepts one event, then presents
    // beats until the one marked last is taken.
    gbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: window base, next sequence number, tick timer and the
    // result register. On accept it applies the event and loads the first
    // beat; on advance it steps the retransmission sequence number on.
    gbn_datapath #(
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .ack_seq     (ack_seq),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .seq_num     (seq_num),
        .outstanding (outstanding),
        .last        (last)
    );

endmodule

@@ sv/gbn_datapath.sv @@
// ---------------------------------------------------------------------------
// gbn_datapath
// Window state, retransmit timer, configuration and the result register.
// ---------------------------------------------------------------------------
module gbn_datapath #(
    parameter int SEQ_MODULUS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic [gbn_pkg::OP_W-1:0]       op,
    input  logic [gbn_pkg::ACK_W-1:0]      ack_seq,
    input  gbn_pkg::gbn_cmd_t              cmd,
    output gbn_pkg::gbn_sts_t              sts,
    output logic [gbn_pkg::KIND_W-1:0]     kind,
    output logic [gbn_pkg::SEQ_OUT_W-1:0]  seq_num,
    output logic [gbn_pkg::OUTST_W-1:0]    outstanding,
    output logic                           last
);
    import gbn_pkg::*;

    localparam int SW = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1;
    localparam logic [SW:0] MOD_W   = (SW+1)'(SEQ_MODULUS);
    localparam logic [8:0]  MOD_9   = 9'(SEQ_MODULUS);
    localparam logic [8:0]  WMAX_9  = 9'(SEQ_MODULUS - 1);
    localparam logic [SW-1:0] SEQ_TOP = SW'(SEQ_MODULUS - 1);

    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == SEQ_TOP) ? '0 : s + 1'b1;
        return r;
    endfunction

    // (a - b) mod M for a, b already below M
    function automatic logic [SW-1:0] seq_dist(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        logic [SW:0] d;
        d = {1'b0, a} + MOD_W - {1'b0, b};
        if (d >= MOD_W)
            d = d - MOD_W;
        return d[SW-1:0];
    endfunction

    // 3-bit ack number reduced modulo M
    function automatic logic [SW-1:0] ack_wrap(input logic [ACK_W-1:0] a);
        logic [8:0] v;
        v = 9'(a);
        for (int i = 0; i < 8; i++) begin
            if (v >= MOD_9)
                v = v - MOD_9;
        end
        return v[SW-1:0];
    endfunction

    logic [WIN_W-1:0]    win_size_reg;
    logic [TIMER_W-1:0]  timeout_reg;
    logic [SW-1:0]       base_reg, base_next;
    logic [SW-1:0]       next_seq_reg, next_seq_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic                running_reg, running_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SW-1:0]       seq_reg, seq_next;
    logic [OUTST_W-1:0]  outst_reg, outst_next;
    logic                last_reg, last_next;
    logic [OUTST_W-1:0]  rem_reg, rem_next;

    logic [SW-1:0]       outst_cur;
    logic [SW-1:0]       ack_w;
    logic [SW-1:0]       ack_d;
    logic [8:0]          win_lim;
    logic [TIMER_W-1:0]  timer_inc;
    logic [8:0]          seq_wide;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg <= WINDOW_SIZE_RST;
            timeout_reg  <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE: win_size_reg <= cfg_data[WIN_W-1:0];
                CFG_TIMEOUT:     timeout_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        outst_cur = seq_dist(next_seq_reg, base_reg);
        ack_w     = ack_wrap(ack_seq);
        ack_d     = seq_dist(ack_w, base_reg);
        win_lim   = (9'(win_size_reg) > WMAX_9) ? WMAX_9 : 9'(win_size_reg);
        timer_inc = (timer_reg < TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;

        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        timer_next    = timer_reg;
        running_next  = running_reg;
        kind_next     = kind_reg;
        seq_next      = seq_reg;
        outst_next    = outst_reg;
        last_next     = last_reg;
        rem_next      = rem_reg;

        if (cmd.accept)
        begin
            // default: one status beat
            kind_next  = KIND_STATUS;
            seq_next   = '0;
            outst_next = OUTST_W'(outst_cur);
            last_next  = 1'b1;
            rem_next   = '0;
            case (op)
                OP_SEND:
                begin
                    if (9'(outst_cur) < win_lim)
                    begin
                        if (outst_cur == '0)
                        begin
                            running_next = 1'b1;
                            timer_next   = '0;
                        end
                        next_seq_next = seq_inc(next_seq_reg);
                        kind_next     = KIND_NEW;
                        seq_next      = next_seq_reg;
                        outst_next    = OUTST_W'(outst_cur) + 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (ack_d < outst_cur)
                    begin
                        base_next    = seq_inc(ack_w);
                        timer_next   = '0;
                        running_next = (seq_inc(ack_w) != next_seq_reg);
                        outst_next   = OUTST_W'(seq_dist(next_seq_reg, seq_inc(ack_w)));
                    end
                end
                OP_TICK:
                begin
                    if (running_reg)
                    begin
                        timer_next = timer_inc;
                        if (timer_inc >= timeout_reg && outst_cur != '0)
                        begin
                            // timeout: go back to the base
                            timer_next = '0;
                            kind_next  = KIND_RETX;
                            seq_next   = base_reg;
                            rem_next   = OUTST_W'(outst_cur) - 1'b1;
                            last_next  = (outst_cur == SW'(1));
                        end
                        else if (outst_cur == '0)
                        begin
                            running_next = 1'b0;
                            timer_next   = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        else if (cmd.advance)
        begin
            seq_next  = seq_inc(seq_reg);
            rem_next  = rem_reg - 1'b1;
            last_next = (rem_reg == OUTST_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            next_seq_reg <= '0;
            timer_reg    <= '0;
            running_reg  <= 1'b0;
        end
        else
        begin
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            timer_reg    <= timer_next;
            running_reg  <= running_next;
        end
    end

    // result register, payload only
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        seq_reg   <= seq_next;
        outst_reg <= outst_next;
        last_reg  <= last_next;
        rem_reg   <= rem_next;
    end

    assign seq_wide    = 9'(seq_reg);
    assign kind        = kind_reg;
    assign seq_num     = seq_wide[SEQ_OUT_W-1:0];
    assign outstanding = outst_reg;
    assign last        = last_reg;
    assign sts.last    = last_reg;

endmodule

@@ sv/gbn_ctrl.sv @@
// ---------------------------------------------------------------------------
// gbn_ctrl
// Handshake controller: take one item, then hand out its beats.
// ---------------------------------------------------------------------------
module gbn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  gbn_pkg::gbn_sts_t sts,
    output gbn_pkg::gbn_cmd_t cmd
);
    import gbn_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd.accept  = in_valid && in_ready_reg;
        cmd.advance = out_valid_reg && out_ready && !sts.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg     <= ST_EMIT;
                        in_ready_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready && sts.last)
                    begin
                        state_reg     <= ST_IDLE;
                        in_ready_reg  <= 1'b1;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule
